@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the cache model RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent, and reports through $error when the property fails.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/lscs_pkg.sv @@
// ----------------------------------------------------------------------------
// lscs_pkg
// Shared types, constants and helpers of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package lscs_pkg;

    // Geometry of the line store.
    localparam int SET_BITS_MAX = 6;
    localparam int NUM_SETS     = 1 << SET_BITS_MAX;
    localparam int WAYS_MAX     = 8;
    localparam int WAY_W        = $clog2(WAYS_MAX);

    // Field widths.
    localparam int ADDR_W    = 64;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int SET_W     = 6;
    localparam int SBITS_W   = 3;
    localparam int WAYS_W    = 4;
    localparam int BOFF_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLK_OFF  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SBITS_W-1:0] RST_SET_BITS = 3'd4;
    localparam logic [WAYS_W-1:0]  RST_WAYS     = 4'd1;
    localparam logic [BOFF_W-1:0]  RST_BLK_OFF  = 4'd4;

    // Access kinds. The spare code behaves as a load.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // Outcome codes.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]       outcome;
        logic             extra_hit;
        logic [SET_W-1:0] set_number;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_out_beat;

    // One cache line and one set row of lines.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  block;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef t_line [WAYS_MAX-1:0] t_row;

    // Lookup result handed from the lookup logic to the top level.
    typedef struct packed {
        logic hit;
        logic evict;
        t_row new_row;
    } t_lookup;

    // Saturating increment of a running total.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lscs_tag_store.sv @@
// ----------------------------------------------------------------------------
// lscs_tag_store
// Row memory of the cache: one row per set holding every way's valid bit,
// block number and age stamp. Registered read, bypass of a same-edge write,
// and per-row valid flops so that never-written rows read as empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lscs_tag_store (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [lscs_pkg::SET_W-1:0] i_rd_set,
    input  wire logic                     i_wr_en,
    input  wire logic [lscs_pkg::SET_W-1:0] i_wr_set,
    input  wire lscs_pkg::t_row           i_wr_row,
    output lscs_pkg::t_row                o_rd_row
);
    import lscs_pkg::*;

    t_row                r_mem [NUM_SETS];
    t_row                r_rd_data;
    t_row                r_fwd_row;
    logic [NUM_SETS-1:0] r_row_vld;
    logic                r_rd_vld;
    logic                r_fwd;
    logic                wr_any_vld;

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
    end

    // Memory read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_set];
        end
    end

    // Row valid flops: a row is live once it has been written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_set] <= 1'b1;
        end
    end

    // Bypass control: a write to the set being read on the same edge wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_row_vld[i_rd_set];
            r_fwd    <= i_wr_en && (i_wr_set == i_rd_set);
        end
    end

    // Bypass payload.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_row <= i_wr_row;
        end
    end

    // Read data as seen by the lookup.
    always_comb begin
        if (r_fwd) begin
            o_rd_row = r_fwd_row;
        end else if (r_rd_vld) begin
            o_rd_row = r_rd_data;
        end else begin
            o_rd_row = '0;
        end
    end

    // Any valid line in the row being written.
    always_comb begin
        wr_any_vld = 1'b0;
        for (int w = 0; w < WAYS_MAX; w++) begin
            wr_any_vld = wr_any_vld | i_wr_row[w].valid;
        end
    end

    // A written row always holds at least one valid line.
    `ASSERT_IMPL(a_wr_row_live, i_clk, i_rst_n, i_wr_en, wr_any_vld)
    // A written row is marked live from the next cycle on.
    `ASSERT_NEXT(a_row_vld_set, i_clk, i_rst_n, i_wr_en, r_row_vld[$past(i_wr_set)])

endmodule

`default_nettype wire

@@ rtl/lscs_lookup.sv @@
// ----------------------------------------------------------------------------
// lscs_lookup
// Combinational lookup of one set row: parallel tag compare over the ways in
// use, first free way search, oldest-stamp victim tree, and the updated row.
// ----------------------------------------------------------------------------
`default_nettype none

module lscs_lookup (
    input  wire lscs_pkg::t_row                   i_row,
    input  wire logic [lscs_pkg::ADDR_W-1:0]      i_block,
    input  wire logic [lscs_pkg::WAYS_W-1:0]      i_ways,
    input  wire logic [lscs_pkg::STAMP_W-1:0]     i_stamp,
    output lscs_pkg::t_lookup                     o_res
);
    import lscs_pkg::*;

    logic [WAYS_MAX-1:0] in_use;
    logic [WAYS_MAX-1:0] match;
    logic [WAYS_MAX-1:0] free;
    logic [WAY_W-1:0]    fill_way;
    logic                any_free;
    logic [STAMP_W:0]    key [WAY_W+1][WAYS_MAX];
    logic [WAY_W-1:0]    kidx [WAY_W+1][WAYS_MAX];
    logic [WAY_W-1:0]    victim;

    // Per-way compare and free detection.
    always_comb begin
        for (int w = 0; w < WAYS_MAX; w++) begin
            in_use[w] = WAYS_W'(w) < i_ways;
            match[w]  = in_use[w] && i_row[w].valid && (i_row[w].block == i_block);
            free[w]   = in_use[w] && !i_row[w].valid;
        end
    end

    // Lowest-numbered free way.
    always_comb begin
        fill_way = '0;
        for (int w = WAYS_MAX - 1; w >= 0; w--) begin
            if (free[w]) begin
                fill_way = WAY_W'(w);
            end
        end
        any_free = |free;
    end

    // Oldest-stamp tree; ways out of use lose, ties go to the lower way.
    always_comb begin
        for (int l = 0; l <= WAY_W; l++) begin
            for (int w = 0; w < WAYS_MAX; w++) begin
                key[l][w]  = '0;
                kidx[l][w] = '0;
            end
        end
        for (int w = 0; w < WAYS_MAX; w++) begin
            key[0][w]  = {!in_use[w], i_row[w].stamp};
            kidx[0][w] = WAY_W'(w);
        end
        for (int l = 0; l < WAY_W; l++) begin
            for (int i = 0; i < (WAYS_MAX >> (l + 1)); i++) begin
                if (key[l][2*i+1] < key[l][2*i]) begin
                    key[l+1][i]  = key[l][2*i+1];
                    kidx[l+1][i] = kidx[l][2*i+1];
                end else begin
                    key[l+1][i]  = key[l][2*i];
                    kidx[l+1][i] = kidx[l][2*i];
                end
            end
        end
        victim = kidx[WAY_W][0];
    end

    // Updated row and outcome.
    always_comb begin
        o_res.hit     = |match;
        o_res.evict   = !(|match) && !any_free;
        o_res.new_row = i_row;
        if (|match) begin
            for (int w = 0; w < WAYS_MAX; w++) begin
                if (match[w]) begin
                    o_res.new_row[w].stamp = i_stamp;
                end
            end
        end else if (any_free) begin
            o_res.new_row[fill_way].valid = 1'b1;
            o_res.new_row[fill_way].block = i_block;
            o_res.new_row[fill_way].stamp = i_stamp;
        end else begin
            o_res.new_row[victim].block = i_block;
            o_res.new_row[victim].stamp = i_stamp;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lru_set_assoc_cache_sim.sv @@
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim
// Set-associative cache model with LRU replacement. Each access beat is
// looked up in its set; the beat's outcome and the running hit, miss and
// eviction totals leave on the result channel.
//
//   channel  direction  handshake                 payload
//   config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//   access   in         i_in_valid / o_in_stall   i_in_beat (t_in_beat)
//   result   out        o_out_valid / i_out_stall o_out_beat (t_out_beat)
//
// One access beat is taken every cycle while the result side does not stall;
// its result follows the set row read, then the lookup and write-back.
// Back-to-back beats to the same set use the write bypass of the row memory.
// Reset needs no clearing pass: 64 row-valid flops mark rows never written.
// A stalled result holds the pipeline; the access side then sees o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_set_assoc_cache_sim (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lscs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lscs_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire lscs_pkg::t_in_beat               i_in_beat,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output lscs_pkg::t_out_beat                   o_out_beat
);
    import lscs_pkg::*;

    // Configuration registers.
    logic [SBITS_W-1:0] r_cfg_set_bits;
    logic [WAYS_W-1:0]  r_cfg_ways;
    logic [BOFF_W-1:0]  r_cfg_blk_off;

    // Lookup stage.
    logic              r_s1_valid;
    logic [1:0]        r_s1_mode;
    logic [ADDR_W-1:0] r_s1_block;
    logic [SET_W-1:0]  r_s1_set;

    // Running state.
    logic [STAMP_W-1:0] r_age;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_miss;
    logic [CNT_W-1:0]   r_evict;

    // Result register.
    logic      r_out_valid;
    t_out_beat r_out_beat;

    // Next values and glue.
    logic [CNT_W-1:0]   n_hits;
    logic [CNT_W-1:0]   n_miss;
    logic [CNT_W-1:0]   n_evict;
    logic               adv;
    logic               in_fire;
    logic               s1_fire;
    logic [SBITS_W-1:0] sbits_eff;
    logic [WAYS_W-1:0]  ways_eff;
    logic [ADDR_W-1:0]  in_block;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   in_set;
    t_row               rd_row;
    t_lookup            lk;

    // Handshake: the pipeline moves whenever the result register can take.
    assign adv        = !r_out_valid || !i_out_stall;
    assign in_fire    = i_in_valid && adv;
    assign s1_fire    = r_s1_valid && adv;
    assign o_in_stall = !adv;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_bits <= RST_SET_BITS;
            r_cfg_ways     <= RST_WAYS;
            r_cfg_blk_off  <= RST_BLK_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_SET_BITS: r_cfg_set_bits <= i_cfg_data[SBITS_W-1:0];
                CFG_IDX_WAYS:     r_cfg_ways     <= i_cfg_data[WAYS_W-1:0];
                CFG_IDX_BLK_OFF:  r_cfg_blk_off  <= i_cfg_data[BOFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective geometry after clamping.
    always_comb begin
        sbits_eff = (r_cfg_set_bits > SBITS_W'(SET_BITS_MAX))
                  ? SBITS_W'(SET_BITS_MAX) : r_cfg_set_bits;
        if (r_cfg_ways == '0) begin
            ways_eff = WAYS_W'(1);
        end else if (r_cfg_ways > WAYS_W'(WAYS_MAX)) begin
            ways_eff = WAYS_W'(WAYS_MAX);
        end else begin
            ways_eff = r_cfg_ways;
        end
    end

    // Block number and set index of the incoming beat.
    assign in_block = i_in_beat.address >> r_cfg_blk_off;
    assign set_mask = ~({SET_W{1'b1}} << sbits_eff);
    assign in_set   = in_block[SET_W-1:0] & set_mask;

    // Lookup stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_fire;
        end
    end

    // Lookup stage payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode  <= i_in_beat.mode;
            r_s1_block <= in_block;
            r_s1_set   <= in_set;
        end
    end

    // Set rows: read on acceptance, written back by the lookup stage.
    lscs_tag_store u_tag_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (adv),
        .i_rd_set (in_set),
        .i_wr_en  (s1_fire),
        .i_wr_set (r_s1_set),
        .i_wr_row (lk.new_row),
        .o_rd_row (rd_row)
    );

    // Tag compare and replacement choice.
    lscs_lookup u_lookup (
        .i_row   (rd_row),
        .i_block (r_s1_block),
        .i_ways  (ways_eff),
        .i_stamp (r_age),
        .o_res   (lk)
    );

    // Updated running totals.
    always_comb begin
        n_hits  = lk.hit ? sat_inc(r_hits) : r_hits;
        n_miss  = lk.hit ? r_miss : sat_inc(r_miss);
        n_evict = lk.evict ? sat_inc(r_evict) : r_evict;
        if (r_s1_mode == MODE_MODIFY) begin
            n_hits = sat_inc(n_hits);
        end
    end

    // Age clock and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age   <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_evict <= '0;
        end else if (s1_fire) begin
            r_age   <= r_age + 1'b1;
            r_hits  <= n_hits;
            r_miss  <= n_miss;
            r_evict <= n_evict;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (lk.hit) begin
                r_out_beat.outcome <= OUT_HIT;
            end else if (lk.evict) begin
                r_out_beat.outcome <= OUT_EVICT;
            end else begin
                r_out_beat.outcome <= OUT_FILL;
            end
            r_out_beat.extra_hit      <= (r_s1_mode == MODE_MODIFY);
            r_out_beat.set_number     <= r_s1_set;
            r_out_beat.hit_total      <= n_hits;
            r_out_beat.miss_total     <= n_miss;
            r_out_beat.eviction_total <= n_evict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Every eviction is also a miss.
    `ASSERT_IMPL(a_evict_le_miss, i_clk, i_rst_n, 1'b1, r_evict <= r_miss)
    // An eviction beat carries a nonzero eviction total.
    `ASSERT_IMPL(a_evict_total, i_clk, i_rst_n,
                 o_out_valid && (o_out_beat.outcome == OUT_EVICT),
                 o_out_beat.eviction_total != '0)

endmodule

`default_nettype wire
